// File: hdl/range_lock_table_macros.svh
// assertion macros for the range lock table
`ifndef RANGE_LOCK_TABLE_MACROS_SVH
`define RANGE_LOCK_TABLE_MACROS_SVH

`ifndef SYNTHESIS

`define RLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("range lock table check failed");

`define RLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("range lock table check failed");

`else

`define RLT_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define RLT_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/rlt_pkg.sv
// shared types and constants of the range lock table
package rlt_pkg;

    localparam int LOCK_SLOTS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 64;

    localparam int FIELD_ADDR_W   = 64;
    localparam int HANDLE_W       = 4;
    localparam int COUNT_W        = 5;
    localparam int IN_TDATA_W     = 136;
    localparam int OUT_TDATA_W    = 16;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOT_HELD = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] grant_handle;
        logic                count_up;
        logic                count_down;
    } decision_t;

endpackage

// File: hdl/rlt_slot_file.sv
// slot storage and parallel overlap compare of the range lock table
module rlt_slot_file #(
    parameter int LOCK_SLOTS = rlt_pkg::LOCK_SLOTS_DEF,
    parameter int ADDR_BITS  = rlt_pkg::ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [ADDR_BITS-1:0]  query_start,
    input  logic [ADDR_BITS-1:0]  query_end,
    input  logic [LOCK_SLOTS-1:0] set_vec,
    input  logic [LOCK_SLOTS-1:0] clr_vec,
    output logic [LOCK_SLOTS-1:0] valid_vec,
    output logic [LOCK_SLOTS-1:0] overlap_vec
);

    logic [LOCK_SLOTS-1:0] valid_reg;
    logic [LOCK_SLOTS-1:0] valid_next;
    logic [ADDR_BITS-1:0]  start_reg [LOCK_SLOTS];
    logic [ADDR_BITS-1:0]  end_reg   [LOCK_SLOTS];

    assign valid_next = (valid_reg & ~clr_vec) | set_vec;
    assign valid_vec  = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            if (set_vec[i]) begin
                start_reg[i] <= query_start;
                end_reg[i]   <= query_end;
            end
        end
    end

    // held [hs, he) and request [rs, re) overlap when hs < re and rs < he
    always_comb begin
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            overlap_vec[i] = (start_reg[i] < query_end) && (query_start < end_reg[i]);
        end
    end

endmodule

// File: hdl/rlt_decide.sv
// grant, conflict and release decision of the range lock table
module rlt_decide #(
    parameter int LOCK_SLOTS = rlt_pkg::LOCK_SLOTS_DEF
) (
    input  logic                         req_type,
    input  logic [rlt_pkg::HANDLE_W-1:0] release_handle,
    input  logic [LOCK_SLOTS-1:0]        valid_vec,
    input  logic [LOCK_SLOTS-1:0]        overlap_vec,
    output logic [LOCK_SLOTS-1:0]        set_vec,
    output logic [LOCK_SLOTS-1:0]        clr_vec,
    output rlt_pkg::decision_t           decision
);

    logic [LOCK_SLOTS-1:0]        free_vec;
    logic [LOCK_SLOTS-1:0]        lowest_free;
    logic [LOCK_SLOTS-1:0]        rel_sel;
    logic [rlt_pkg::HANDLE_W-1:0] free_handle;
    logic                         conflict;
    logic                         full;
    logic                         held_hit;

    assign free_vec    = ~valid_vec;
    assign lowest_free = free_vec & (~free_vec + LOCK_SLOTS'(1));
    assign full        = ~|free_vec;
    assign conflict    = |(valid_vec & overlap_vec);
    assign held_hit    = |(rel_sel & valid_vec);

    // slot numbers wrap to the handle field width
    always_comb begin
        free_handle = '0;
        rel_sel     = '0;
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            if (lowest_free[i]) begin
                free_handle = free_handle | rlt_pkg::HANDLE_W'(i);
            end
            rel_sel[i] = (32'(release_handle) == 32'(i));
        end
    end

    always_comb begin
        set_vec  = '0;
        clr_vec  = '0;
        decision = '{status: rlt_pkg::ST_OK, grant_handle: '0,
                     count_up: 1'b0, count_down: 1'b0};
        unique case (req_type)
            rlt_pkg::REQ_ACQUIRE: begin
                if (conflict) begin
                    decision.status = rlt_pkg::ST_CONFLICT;
                end else if (full) begin
                    decision.status = rlt_pkg::ST_FULL;
                end else begin
                    set_vec               = lowest_free;
                    decision.grant_handle = free_handle;
                    decision.count_up     = 1'b1;
                end
            end
            rlt_pkg::REQ_RELEASE: begin
                if (held_hit) begin
                    clr_vec             = rel_sel & valid_vec;
                    decision.count_down = 1'b1;
                end else begin
                    decision.status = rlt_pkg::ST_NOT_HELD;
                end
            end
        endcase
    end

endmodule

// File: hdl/range_lock_table.sv
// range lock table top level: input register, decision, result register
//
// usage: a table of held half-open address ranges [start, end)
// s_ channel carries requests; s_tuser is the request kind, 0 acquire, 1 release
// an acquire is refused on overlap with any held range, refused when the
// table is full, else stored in the lowest free slot whose number is returned
// a release frees the slot named by its handle or reports it as not held
// m_ channel returns one result item for every request item
// a taken request enters the input register and its result then the result register
// throughput: one item per cycle while m_tready is high; all slots are compared
// in parallel in the single logic stage between the input register and the result
// register, and the slot table is updated at the same edge so the next item sees it
// reset: aresetn low at a rising edge empties the table, clears the held count
// and drops both valid flags
// stall: with m_tready low the result register holds its item, the input
// register takes one more item and then s_tready goes low
`include "range_lock_table_macros.svh"

module range_lock_table #(
    parameter int LOCK_SLOTS = rlt_pkg::LOCK_SLOTS_DEF,
    parameter int ADDR_BITS  = rlt_pkg::ADDR_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // range_start [63:0], range_end [127:64], release_handle [131:128], zero pad
    input  logic [rlt_pkg::IN_TDATA_W-1:0]  s_tdata,
    // req_type [0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [1:0], grant_handle [5:2], held_count [10:6], zero pad
    output logic [rlt_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(LOCK_SLOTS + 1);
    localparam int AW    = rlt_pkg::FIELD_ADDR_W;
    localparam int HW    = rlt_pkg::HANDLE_W;

    logic                  in_vld_reg;
    logic                  in_type_reg;
    logic [ADDR_BITS-1:0]  in_start_reg;
    logic [ADDR_BITS-1:0]  in_end_reg;
    logic [HW-1:0]         in_handle_reg;

    logic                  out_vld_reg;
    rlt_pkg::status_t      out_status_reg;
    logic [HW-1:0]         out_grant_reg;
    logic [rlt_pkg::COUNT_W-1:0] out_count_reg;

    logic [CNT_W-1:0]      held_total_reg;
    logic [CNT_W-1:0]      held_total_next;

    logic                  advance;
    logic                  s_accept;
    logic [LOCK_SLOTS-1:0] valid_vec;
    logic [LOCK_SLOTS-1:0] overlap_vec;
    logic [LOCK_SLOTS-1:0] set_raw;
    logic [LOCK_SLOTS-1:0] clr_raw;
    logic [LOCK_SLOTS-1:0] set_vec;
    logic [LOCK_SLOTS-1:0] clr_vec;
    rlt_pkg::decision_t    decision;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign set_vec  = set_raw & {LOCK_SLOTS{advance}};
    assign clr_vec  = clr_raw & {LOCK_SLOTS{advance}};

    rlt_slot_file #(
        .LOCK_SLOTS (LOCK_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_slot_file (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .query_start (in_start_reg),
        .query_end   (in_end_reg),
        .set_vec     (set_vec),
        .clr_vec     (clr_vec),
        .valid_vec   (valid_vec),
        .overlap_vec (overlap_vec)
    );

    rlt_decide #(
        .LOCK_SLOTS (LOCK_SLOTS)
    ) u_decide (
        .req_type       (in_type_reg),
        .release_handle (in_handle_reg),
        .valid_vec      (valid_vec),
        .overlap_vec    (overlap_vec),
        .set_vec        (set_raw),
        .clr_vec        (clr_raw),
        .decision       (decision)
    );

    always_comb begin
        held_total_next = held_total_reg;
        if (decision.count_up) begin
            held_total_next = held_total_reg + CNT_W'(1);
        end else if (decision.count_down) begin
            held_total_next = held_total_reg - CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            held_total_reg <= '0;
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg    <= 1'b1;
                held_total_reg <= held_total_next;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg   <= s_tuser;
            in_start_reg  <= s_tdata[ADDR_BITS-1:0];
            in_end_reg    <= s_tdata[AW+ADDR_BITS-1:AW];
            in_handle_reg <= s_tdata[2*AW+HW-1:2*AW];
        end
        if (advance) begin
            out_status_reg <= decision.status;
            out_grant_reg  <= decision.grant_handle;
            out_count_reg  <= rlt_pkg::COUNT_W'(held_total_next);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {(rlt_pkg::OUT_TDATA_W - rlt_pkg::COUNT_W - HW - 2)'(0),
                       out_count_reg, out_grant_reg, out_status_reg};

    `RLT_ASSERT_IMP(a_count_matches_slots, aclk, aresetn, 1'b1,
        32'(held_total_reg) == $countones(valid_vec))
    `RLT_ASSERT_IMP(a_single_slot_set, aclk, aresetn, 1'b1, $onehot0(set_vec))
    `RLT_ASSERT_NXT(a_grant_fills_slot, aclk, aresetn,
        advance && (in_type_reg == rlt_pkg::REQ_ACQUIRE) && (decision.status == rlt_pkg::ST_OK),
        $countones(valid_vec) == $countones($past(valid_vec)) + 1)

endmodule

// File: verif/range_lock_table_checker.sv
// checker for the range lock table: mirrors the slot table and compares each result item
module range_lock_table_checker
    import rlt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // range_start [63:0], range_end [127:64], release_handle [131:128], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type [0]
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // status [1:0], grant_handle [5:2], held_count [10:6], zero pad
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     req_count,
    output int                     res_count,
    output int                     pending
);

    localparam int SLOTS = LOCK_SLOTS_DEF;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  held;
    } lock_outcome_t;

    logic                    slot_busy [SLOTS];
    logic [FIELD_ADDR_W-1:0] slot_lo   [SLOTS];
    logic [FIELD_ADDR_W-1:0] slot_hi   [SLOTS];
    logic [COUNT_W-1:0]      held_now;
    lock_outcome_t           outcome_q [$];
    int                      fails_seen;
    int                      reqs_seen;
    int                      ress_seen;

    initial begin
        fails_seen = 0;
        reqs_seen  = 0;
        ress_seen  = 0;
        held_now   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_lo[i]   = '0;
            slot_hi[i]   = '0;
        end
    end

    // applies one request to the mirrored table and returns its outcome
    function automatic lock_outcome_t apply_request(input logic kind,
                                                    input logic [FIELD_ADDR_W-1:0] lo,
                                                    input logic [FIELD_ADDR_W-1:0] hi,
                                                    input logic [HANDLE_W-1:0] h);
        lock_outcome_t res;
        logic          clash;
        int            free_idx;
        int            i;
        res.status = ST_OK;
        res.handle = '0;
        clash      = 1'b0;
        free_idx   = -1;
        if (kind == REQ_ACQUIRE) begin
            for (i = 0; i < SLOTS; i++) begin
                if (slot_busy[i]) begin
                    if (!(slot_lo[i] >= hi) && !(lo >= slot_hi[i]))
                        clash = 1'b1;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (clash) begin
                res.status = ST_CONFLICT;
            end else if (free_idx < 0) begin
                res.status = ST_FULL;
            end else begin
                slot_busy[free_idx] = 1'b1;
                slot_lo[free_idx]   = lo;
                slot_hi[free_idx]   = hi;
                held_now            = held_now + 1'b1;
                res.handle          = free_idx[HANDLE_W-1:0];
            end
        end else begin
            if (int'(h) < SLOTS && slot_busy[h]) begin
                slot_busy[h] = 1'b0;
                held_now     = held_now - 1'b1;
            end else begin
                res.status = ST_NOT_HELD;
            end
        end
        res.held = held_now;
        return res;
    endfunction

    always @(posedge aclk) begin
        lock_outcome_t want;
        lock_outcome_t got;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) slot_busy[i] = 1'b0;
            held_now = '0;
            outcome_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tdata[1:0]);
                got.handle = m_tdata[5:2];
                got.held   = m_tdata[10:6];
                ress_seen++;
                if (outcome_q.size() == 0) begin
                    $error("result item with no request waiting: status %0d handle %0d held %0d",
                           got.status, got.handle, got.held);
                    fails_seen++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails_seen++;
                    end
                    if (got.handle !== want.handle) begin
                        $error("grant_handle mismatch: expected %0d, actual %0d",
                               want.handle, got.handle);
                        fails_seen++;
                    end
                    if (got.held !== want.held) begin
                        $error("held_count mismatch: expected %0d, actual %0d",
                               want.held, got.held);
                        fails_seen++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(apply_request(s_tuser, s_tdata[63:0], s_tdata[127:64],
                                                  s_tdata[131:128]));
                reqs_seen++;
            end
        end
        fail_count <= fails_seen;
        req_count  <= reqs_seen;
        res_count  <= ress_seen;
        pending    <= outcome_q.size();
    end

endmodule

// File: verif/range_lock_table_tb.sv
// testbench top for the range lock table: clock, reset, stimulus, backpressure and verdict
module range_lock_table_tb;
    import rlt_pkg::*;

    localparam int DIRECTED_N = 25;
    localparam int RANDOM_N   = 500;
    localparam int ITEM_TOTAL = DIRECTED_N + RANDOM_N;
    localparam int QUIET_FROM = ITEM_TOTAL - 100;
    localparam int PAUSE_AT   = 250;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_LEN   = 80;
    localparam int IDLE_LIMIT = 3000;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int req_count;
    int res_count;
    int pending;
    int sent = 0;

    range_lock_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    range_lock_table_checker lock_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .req_count  (req_count),
        .res_count  (res_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // offers one item and waits for its handshake, then maybe leaves a gap
    task automatic offer_request(input logic kind,
                                 input logic [FIELD_ADDR_W-1:0] lo,
                                 input logic [FIELD_ADDR_W-1:0] hi,
                                 input logic [HANDLE_W-1:0] h);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, h, hi, lo};
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    function automatic logic [FIELD_ADDR_W-1:0] any_addr();
        return {$urandom, $urandom};
    endfunction

    initial begin : stimulus
        logic [FIELD_ADDR_W-1:0] lo;
        logic [FIELD_ADDR_W-1:0] hi;
        logic [FIELD_ADDR_W-1:0] ones;
        int                      acq_pct;
        int                      pick;
        ones = '1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty and inverted ranges at the address extremes, then a full-span range
        offer_request(REQ_ACQUIRE, '0, '0, 4'd15);
        offer_request(REQ_ACQUIRE, ones, '0, 4'd0);
        offer_request(REQ_ACQUIRE, '0, ones, 4'd7);
        offer_request(REQ_ACQUIRE, 64'd5, 64'd10, 4'd0);
        offer_request(REQ_RELEASE, ones, ones, 4'd2);
        offer_request(REQ_RELEASE, '0, '0, 4'd2);
        offer_request(REQ_RELEASE, any_addr(), any_addr(), 4'd15);
        // touching ranges, a straddle, an empty range inside a held one
        offer_request(REQ_ACQUIRE, 64'd100, 64'd200, 4'd9);
        offer_request(REQ_ACQUIRE, 64'd200, 64'd300, 4'd3);
        offer_request(REQ_ACQUIRE, 64'd199, 64'd201, 4'd0);
        offer_request(REQ_ACQUIRE, 64'd150, 64'd150, 4'd0);
        // fill the table, then full alone and full with an overlap
        for (int k = 0; k < 12; k++)
            offer_request(REQ_ACQUIRE, 64'd1000 + 16 * k, 64'd1008 + 16 * k,
                          4'($urandom_range(0, 15)));
        offer_request(REQ_ACQUIRE, 64'd5000, 64'd5001, 4'd0);
        offer_request(REQ_ACQUIRE, 64'd1000, 64'd1001, 4'd0);

        for (int n = 0; n < RANDOM_N; n++) begin
            if (n == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            // alternate fill-heavy and drain-heavy stretches
            acq_pct = ((n / 40) % 2 == 0) ? 70 : 30;
            if ($urandom_range(0, 99) < acq_pct) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    lo = any_addr();
                    hi = any_addr();
                end else if (pick < 14) begin
                    lo = 64'($urandom_range(64, 2047));
                    hi = lo - 64'($urandom_range(1, 64));
                end else if (pick < 18) begin
                    lo = 64'($urandom_range(0, 2047));
                    hi = lo;
                end else begin
                    lo = 64'($urandom_range(0, 2047));
                    hi = lo + 64'($urandom_range(1, 96));
                end
                offer_request(REQ_ACQUIRE, lo, hi, 4'($urandom_range(0, 15)));
            end else begin
                offer_request(REQ_RELEASE, any_addr(), any_addr(), 4'($urandom_range(0, 15)));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        bit long_done;
        stall_left = 0;
        long_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!long_done && res_count >= HOLD_AFTER) begin
                // long hold-off so the block fills and stalls its input
                long_done  = 1'b1;
                stall_left = HOLD_LEN - 1;
                m_tready   <= 1'b0;
            end else if (req_count < QUIET_FROM && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: range_lock_table.f
+incdir+hdl
hdl/rlt_pkg.sv
hdl/rlt_slot_file.sv
hdl/rlt_decide.sv
hdl/range_lock_table.sv
verif/range_lock_table_checker.sv
verif/range_lock_table_tb.sv
